// ----- rtl/block_average_mosaic_top_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for block_average_mosaic
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef BLOCK_AVERAGE_MOSAIC_TOP_DEFINES_SVH
`define BLOCK_AVERAGE_MOSAIC_TOP_DEFINES_SVH

// checked property outside reset
`define BAM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("block_average_mosaic assertion failed");

// checked property during reset as well
`define BAM_ASSERT_RST(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("block_average_mosaic reset assertion failed");

`endif

// ----- rtl/bam_pkg.sv -----
// ---------------------------------------------------------------------------
// bam_pkg
// Types and constants shared by the block average mosaic modules.
// ---------------------------------------------------------------------------
package bam_pkg;

	localparam int unsigned MaxWidth   = 4096;
	localparam int unsigned MaxBlock   = 64;
	localparam int unsigned MaxHeight  = 4096;
	localparam int unsigned IdxW       = 12;
	localparam int unsigned SumW       = 20;
	localparam int unsigned DivNumW    = 21;
	localparam int unsigned DivDenW    = 13;
	localparam int unsigned CfgW       = 13;

	localparam logic [1:0] RegImageWidth  = 2'd0;
	localparam logic [1:0] RegImageHeight = 2'd1;
	localparam logic [1:0] RegBlockSize   = 2'd2;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic       frame_start;
	} pixel_t;

	typedef struct packed {
		logic [11:0] block_column;
		logic [11:0] block_row;
		logic [7:0]  red_avg;
		logic [7:0]  green_avg;
		logic [7:0]  blue_avg;
		logic        frame_done;
	} block_t;

	typedef struct packed {
		logic load_pix;
		logic start_col_div;
		logic cap_idx;
		logic mem_rd;
		logic acc;
		logic start_blk_div;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic block_end;
	} status_t;

endpackage

// ----- rtl/bam_div.sv -----
// ---------------------------------------------------------------------------
// bam_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bam_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bam_pkg::DivNumW-1:0]  dividend,
	input  logic [bam_pkg::DivDenW-1:0]  divisor,
	output logic                         done,
	output logic [bam_pkg::DivNumW-1:0]  quotient
);
	import bam_pkg::*;

	localparam int unsigned CntW = $clog2(DivNumW + 1);

	logic [DivDenW:0]   rem_q;
	logic [DivNumW-1:0] quo_q;
	logic [DivDenW-1:0] den_q;
	logic [CntW-1:0]    cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DivDenW:0]   trial;
	logic               ge;

	assign trial = {rem_q[DivDenW-1:0], quo_q[DivNumW-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(DivNumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial - {1'b0, den_q} : trial;
			quo_q <= {quo_q[DivNumW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/bam_dp.sv -----
// ---------------------------------------------------------------------------
// bam_dp
// Datapath: registers, position counters, accumulator memories, dividers.
// ---------------------------------------------------------------------------
module bam_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [bam_pkg::CfgW-1:0]   cfg_data,
	input  bam_pkg::pixel_t            in_data,
	input  bam_pkg::cmd_t              cmd,
	output bam_pkg::status_t           status,
	output bam_pkg::block_t            out_data
);
	import bam_pkg::*;

	logic [12:0] width_q, height_q;
	logic [6:0]  bsize_q;
	logic [12:0] w_eff, h_eff;
	logic [6:0]  bs_eff;

	pixel_t      pix_q;
	logic [11:0] col_q, line_q;
	logic [5:0]  ox_q, oy_q;
	logic [IdxW-1:0] idx_q;
	logic [11:0] line_pix_q;
	logic [12:0] cnt_q;
	logic        fdone_q;
	logic [SumW-1:0] rd_r_q, rd_g_q, rd_b_q;
	logic [SumW-1:0] sum_r_q, sum_g_q, sum_b_q;
	logic [SumW-1:0] new_r, new_g, new_b;
	logic [SumW-1:0] mem_r [MaxWidth];
	logic [SumW-1:0] mem_g [MaxWidth];
	logic [SumW-1:0] mem_b [MaxWidth];
	block_t      out_q;

	logic line_end, frame_end, last_x, last_y, first;
	logic [13:0] cnt_full;

	logic                d_start0, d_done0, d_done1, d_done2, d_done3;
	logic [DivNumW-1:0]  d_num0, q0, q1, q2, q3;
	logic [DivNumW-1:0]  num_r, num_g, num_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd64;
			height_q <= 13'd64;
			bsize_q  <= 7'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				RegImageWidth:  width_q  <= cfg_data;
				RegImageHeight: height_q <= cfg_data;
				RegBlockSize:   bsize_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		w_eff  = (width_q == '0) ? 13'd1 :
			(width_q > 13'(MaxWidth)) ? 13'(MaxWidth) : width_q;
		h_eff  = (height_q == '0) ? 13'd1 :
			(height_q > 13'(MaxHeight)) ? 13'(MaxHeight) : height_q;
		bs_eff = (bsize_q == '0) ? 7'd1 :
			(bsize_q > 7'(MaxBlock)) ? 7'(MaxBlock) : bsize_q;
	end

	assign line_end  = {1'b0, col_q} >= w_eff - 13'd1;
	assign last_y    = ({1'b0, line_q} >= h_eff - 13'd1) || ({1'b0, oy_q} >= bs_eff - 7'd1);
	assign frame_end = line_end && ({1'b0, line_q} >= h_eff - 13'd1);
	assign last_x    = line_end || ({1'b0, ox_q} >= bs_eff - 7'd1);
	assign first     = (ox_q == '0) && (oy_q == '0);
	assign cnt_full  = ({1'b0, ox_q} + 7'd1) * ({1'b0, oy_q} + 7'd1);

	assign new_r = first ? SumW'(pix_q.red_in)   : rd_r_q + SumW'(pix_q.red_in);
	assign new_g = first ? SumW'(pix_q.green_in) : rd_g_q + SumW'(pix_q.green_in);
	assign new_b = first ? SumW'(pix_q.blue_in)  : rd_b_q + SumW'(pix_q.blue_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			line_q <= '0;
			ox_q   <= '0;
			oy_q   <= '0;
		end else if (cmd.load_pix && in_data.frame_start) begin
			col_q  <= '0;
			line_q <= '0;
			ox_q   <= '0;
			oy_q   <= '0;
		end else if (cmd.acc) begin
			if (line_end) begin
				col_q <= '0;
				ox_q  <= '0;
				if (frame_end) begin
					line_q <= '0;
					oy_q   <= '0;
				end else begin
					line_q <= line_q + 12'd1;
					oy_q   <= ({1'b0, oy_q} >= bs_eff - 7'd1) ? 6'd0 : oy_q + 6'd1;
				end
			end else begin
				col_q <= col_q + 12'd1;
				ox_q  <= ({1'b0, ox_q} >= bs_eff - 7'd1) ? 6'd0 : ox_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_pix)
			pix_q <= in_data;
		if (cmd.cap_idx && d_done0)
			idx_q <= q0[IdxW-1:0];
		if (cmd.mem_rd) begin
			rd_r_q <= mem_r[idx_q];
			rd_g_q <= mem_g[idx_q];
			rd_b_q <= mem_b[idx_q];
		end
		if (cmd.acc) begin
			mem_r[idx_q] <= new_r;
			mem_g[idx_q] <= new_g;
			mem_b[idx_q] <= new_b;
			sum_r_q      <= new_r;
			sum_g_q      <= new_g;
			sum_b_q      <= new_b;
			line_pix_q   <= line_q;
			cnt_q        <= cnt_full[12:0];
			fdone_q      <= frame_end;
		end
		if (cmd.load_out) begin
			out_q.block_column <= idx_q;
			out_q.block_row    <= q0[11:0];
			out_q.red_avg      <= q1[7:0];
			out_q.green_avg    <= q2[7:0];
			out_q.blue_avg     <= q3[7:0];
			out_q.frame_done   <= fdone_q;
		end
	end

	assign d_start0 = cmd.start_col_div || cmd.start_blk_div;
	assign d_num0   = cmd.start_col_div ? DivNumW'(col_q) : DivNumW'(line_pix_q);
	assign num_r    = DivNumW'(sum_r_q) + DivNumW'(cnt_q[12:1]);
	assign num_g    = DivNumW'(sum_g_q) + DivNumW'(cnt_q[12:1]);
	assign num_b    = DivNumW'(sum_b_q) + DivNumW'(cnt_q[12:1]);

	bam_div u_div_pos (.clk, .arst_n, .start(d_start0), .dividend(d_num0),
		.divisor(DivDenW'(bs_eff)), .done(d_done0), .quotient(q0));
	bam_div u_div_r (.clk, .arst_n, .start(cmd.start_blk_div), .dividend(num_r),
		.divisor(cnt_q), .done(d_done1), .quotient(q1));
	bam_div u_div_g (.clk, .arst_n, .start(cmd.start_blk_div), .dividend(num_g),
		.divisor(cnt_q), .done(d_done2), .quotient(q2));
	bam_div u_div_b (.clk, .arst_n, .start(cmd.start_blk_div), .dividend(num_b),
		.divisor(cnt_q), .done(d_done3), .quotient(q3));

	assign status.div_done  = d_done0 && (cmd.cap_idx || (d_done1 && d_done2 && d_done3));
	assign status.block_end = last_x && last_y;
	assign out_data         = out_q;

endmodule

// ----- rtl/bam_ctrl.sv -----
// ---------------------------------------------------------------------------
// bam_ctrl
// Sequencer: one pixel at a time through divide, read, accumulate, and average when a block closes.
// ---------------------------------------------------------------------------
module bam_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  bam_pkg::status_t  status,
	output bam_pkg::cmd_t     cmd
);
	import bam_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_CGO, S_CDIV, S_RD, S_ACC, S_BGO, S_BDIV, S_HOLD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd               = '0;
		cmd.load_pix      = (state_q == S_IDLE) && in_valid;
		cmd.start_col_div = state_q == S_CGO;
		cmd.cap_idx       = state_q == S_CDIV;
		cmd.mem_rd        = state_q == S_RD;
		cmd.acc           = state_q == S_ACC;
		cmd.start_blk_div = state_q == S_BGO;
		cmd.load_out      = ((state_q == S_BDIV && status.div_done) || state_q == S_HOLD)
			&& out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_CGO;
				S_CGO:  state_q <= S_CDIV;
				S_CDIV: if (status.div_done) state_q <= S_RD;
				S_RD:   state_q <= S_ACC;
				S_ACC:  state_q <= status.block_end ? S_BGO : S_IDLE;
				S_BGO:  state_q <= S_BDIV;
				S_BDIV: if (status.div_done) state_q <= out_free ? S_IDLE : S_HOLD;
				S_HOLD: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

endmodule

// ----- rtl/block_average_mosaic_top.sv -----
// A pixel that closes no block passes the states CGO, CDIV, RD and ACC before the next accept.
// A block-closing pixel then passes BGO and BDIV, and HOLD while the output is stalled.
// Pixels are taken one at a time; in_stall stays high through the 21-step block index divide.
// Reset (arst_n low) clears positions, registers to 64/64/8, and the output valid;
// accumulator memories are not cleared, each entry is written first at its block's start.
// ---------------------------------------------------------------------------
// block_average_mosaic_top
// Block-average pixelation of a raster RGB pixel stream.
// ---------------------------------------------------------------------------
module block_average_mosaic_top (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [bam_pkg::CfgW-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  bam_pkg::pixel_t          in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output bam_pkg::block_t          out_data
);
	import bam_pkg::*;

	cmd_t    cmd;
	status_t status;

	bam_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.status, .cmd
	);

	bam_dp u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .in_data,
		.cmd, .status, .out_data
	);

endmodule

// ----- rtl/bam_checker.sv -----
// ---------------------------------------------------------------------------
// bam_checker
// Port-level checks for the block average mosaic, bound to the top level.
// ---------------------------------------------------------------------------
`include "block_average_mosaic_top_defines.svh"

module bam_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_stall,
	input  logic            out_valid,
	input  logic            out_stall,
	input  bam_pkg::block_t out_data
);
	import bam_pkg::*;

	`BAM_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(out_data))
	`BAM_ASSERT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall |=> in_stall)
	`BAM_ASSERT(a_result_from_work, clk, arst_n, $rose(out_valid) |-> $past(in_stall))
	`BAM_ASSERT_RST(a_reset_quiet, clk, !arst_n && $past(!arst_n) |-> !out_valid && !in_stall)

endmodule

bind block_average_mosaic_top bam_checker u_bam_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);

// ----- tb/block_average_mosaic_checker.sv -----
// ---------------------------------------------------------------------------
// block_average_mosaic_checker
// Watches the pixel and block channels and the register port, predicts each
// block average and compares it field by field against the block output.
// ---------------------------------------------------------------------------
module block_average_mosaic_checker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [bam_pkg::CfgW-1:0] cfg_data,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  bam_pkg::pixel_t          in_data,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  bam_pkg::block_t          out_data,
	output int                       fail_count,
	output int                       pending,
	output int                       blocks_seen
);
	import bam_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic [12:0] width_reg, height_reg;
	logic [6:0]  bsize_reg;
	int unsigned col, line, offx, offy;
	int unsigned red_acc[MaxWidth], grn_acc[MaxWidth], blu_acc[MaxWidth];
	block_t      block_q[$];

	assign pending = block_q.size();

	function automatic int unsigned clampv(int unsigned v, int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic logic [7:0] avg(int unsigned s, int unsigned n);
		return 8'((s + n / 2) / n);
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic predict_pixel(pixel_t p);
		int unsigned w, h, bs, idx, cnt;
		logic le, fe, lx, ly;
		block_t b;
		w  = clampv(width_reg, MaxWidth);
		h  = clampv(height_reg, MaxHeight);
		bs = clampv(bsize_reg, MaxBlock);
		if (p.frame_start) begin
			col = 0; line = 0; offx = 0; offy = 0;
		end
		idx = (col / bs) % MaxWidth;
		if (offx == 0 && offy == 0) begin
			red_acc[idx] = p.red_in; grn_acc[idx] = p.green_in; blu_acc[idx] = p.blue_in;
		end else begin
			red_acc[idx] += p.red_in; grn_acc[idx] += p.green_in; blu_acc[idx] += p.blue_in;
		end
		le = col >= w - 1;
		fe = le && line >= h - 1;
		lx = le || offx >= bs - 1;
		ly = line >= h - 1 || offy >= bs - 1;
		if (lx && ly) begin
			cnt = (offx + 1) * (offy + 1);
			b.block_column = 12'(col / bs);
			b.block_row    = 12'(line / bs);
			b.red_avg      = avg(red_acc[idx], cnt);
			b.green_avg    = avg(grn_acc[idx], cnt);
			b.blue_avg     = avg(blu_acc[idx], cnt);
			b.frame_done   = fe;
			block_q.insert(block_q.size(), b);
		end
		if (le) begin
			col = 0; offx = 0;
			if (fe) begin
				line = 0; offy = 0;
			end else begin
				line++;
				offy = (offy >= bs - 1) ? 0 : offy + 1;
			end
		end else begin
			col++;
			offx = (offx >= bs - 1) ? 0 : offx + 1;
		end
	endtask

	initial fail_count = 0;
	initial blocks_seen = 0;

	always @(posedge clk or negedge arst_n) begin
		block_t e;
		if (!arst_n) begin
			width_reg <= 13'd64; height_reg <= 13'd64; bsize_reg <= 7'd8;
			col = 0; line = 0; offx = 0; offy = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					RegImageWidth:  width_reg  <= cfg_data;
					RegImageHeight: height_reg <= cfg_data;
					RegBlockSize:   bsize_reg  <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) predict_pixel(in_data);
			if (out_valid && !out_stall) begin
				blocks_seen++;
				if (block_q.size() == 0) begin
					report("unexpected block", out_data.block_column, 0);
				end else begin
					e = block_q.pop_front();
					if (out_data.block_column !== e.block_column)
						report("block_column", out_data.block_column, e.block_column);
					if (out_data.block_row !== e.block_row)
						report("block_row", out_data.block_row, e.block_row);
					if (out_data.red_avg !== e.red_avg)
						report("red_avg", out_data.red_avg, e.red_avg);
					if (out_data.green_avg !== e.green_avg)
						report("green_avg", out_data.green_avg, e.green_avg);
					if (out_data.blue_avg !== e.blue_avg)
						report("blue_avg", out_data.blue_avg, e.blue_avg);
					if (out_data.frame_done !== e.frame_done)
						report("frame_done", out_data.frame_done, e.frame_done);
				end
			end
		end
	end
endmodule

// ----- tb/block_average_mosaic_top_tb.sv -----
// ---------------------------------------------------------------------------
// block_average_mosaic_top_tb
// Drives whole frames of random and directed pixels under several image and block sizes,
// with random source gaps and sink stalls; the checker judges every block.
// ---------------------------------------------------------------------------
module block_average_mosaic_top_tb;
	import bam_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchdogLimit = 20000;

	logic                clk, arst_n;
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [CfgW-1:0]     cfg_data;
	logic                in_valid, in_stall, out_valid, out_stall;
	pixel_t              in_data;
	block_t              out_data;
	int                  fail_count, pending, blocks_seen;
	int                  idle_cycles, pixels_sent, frames_sent;
	logic                stall_run;

	block_average_mosaic_top DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data)
	);

	block_average_mosaic_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data), .fail_count(fail_count), .pending(pending),
		.blocks_seen(blocks_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	// sink stalls, with stall-free stretches
	initial begin
		int n;
		out_stall = 1'b0;
		stall_run = 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 299) == 0) stall_run <= ~stall_run;
			n = stall_run ? 0 : gap_len();
			out_stall <= (n != 0);
			repeat (n) @(posedge clk);
			if (n != 0) out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("watchdog: no progress, %0d blocks pending", pending);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [CfgW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic send_pixel(pixel_t p);
		int g;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pixels_sent++;
	endtask

	// kind: 0 random, 1 all zero, 2 all max, 3 halves for rounding
	task automatic send_frame(int w, int h, int kind);
		pixel_t p;
		for (int i = 0; i < w * h; i++) begin
			p.red_in   = 8'($urandom);
			p.green_in = 8'($urandom);
			p.blue_in  = 8'($urandom);
			if (kind == 1) begin
				p.red_in = 0; p.green_in = 0; p.blue_in = 0;
			end else if (kind == 2) begin
				p.red_in = 8'hff; p.green_in = 8'hff; p.blue_in = 8'hff;
			end else if (kind == 3) begin
				p.red_in = (i % 2) ? 8'd1 : 8'd0;
				p.green_in = (i % 2) ? 8'd254 : 8'd255;
				p.blue_in = 8'(i);
			end
			p.frame_start = (i == 0);
			send_pixel(p);
		end
		frames_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic configure(int w, int h, int bs);
		write_reg(RegImageWidth, CfgW'(w));
		write_reg(RegImageHeight, CfgW'(h));
		write_reg(RegBlockSize, CfgW'(bs));
	endtask

	initial begin
		int w, h, bs;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = RegImageWidth; cfg_data = '0;
		in_valid = 1'b0; in_data = '0;
		idle_cycles = 0; pixels_sent = 0; frames_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero registers act as one, extremes of pixel values, rounding
		configure(0, 0, 0);
		send_frame(1, 1, 2);
		send_frame(1, 1, 1);
		drain();
		configure(3, 2, 2);
		send_frame(3, 2, 3);
		send_frame(3, 2, 2);
		drain();
		// wide line with an oversized block size that saturates
		configure(130, 1, 127);
		send_frame(130, 1, 0);
		drain();
		configure(1, 3, 64);
		send_frame(1, 3, 0);
		drain();

		// random frames, mostly small
		while (pixels_sent < 850) begin
			w  = $urandom_range(1, 12);
			h  = $urandom_range(1, 8);
			bs = $urandom_range(1, 5);
			if ($urandom_range(0, 9) == 0) bs = 64;
			configure(w, h, bs);
			repeat ($urandom_range(1, 3)) send_frame(w, h, ($urandom_range(0, 7) == 0) ? 2 : 0);
			drain();
		end
		// tall image across many block rows
		configure(2, 300, 7);
		send_frame(2, 300, 0);
		drain();

		$display("covered %0d pixels in %0d frames, %0d blocks checked",
			pixels_sent, frames_sent, blocks_seen);
		$display("register sweep included zero sizes and a saturating block size");
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/bam_pkg.sv
rtl/bam_div.sv
rtl/bam_dp.sv
rtl/bam_ctrl.sv
rtl/block_average_mosaic_top.sv
rtl/bam_checker.sv
tb/block_average_mosaic_checker.sv
tb/block_average_mosaic_top_tb.sv
